// ===== rtl/core/ufj_pkg.sv =====
// ----------------------------------------------------------------------------
// ufj_pkg
// Shared constants, types and helpers of the grid union-find edge joiner.
// ----------------------------------------------------------------------------
package ufj_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  localparam int COORD_W = 6;
  localparam int DIM_W   = 7;

  localparam logic DIR_RIGHT   = 1'b0;
  localparam logic DIR_FORWARD = 1'b1;

  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  typedef logic [CELL_AW-1:0] cell_idx_t;

  typedef struct packed {
    logic      is_root;
    cell_idx_t up;
  } ufj_entry_t;

  localparam int ENTRY_W = $bits(ufj_entry_t);

  typedef struct packed {
    cell_idx_t origin;
    cell_idx_t end_cell;
    logic      bad;
  } ufj_req_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic carved;
  } ufj_stat_t;

  function automatic cell_idx_t cell_index(input logic [COORD_W-1:0] x,
                                           input logic [COORD_W-1:0] y);
    cell_idx_t prod;
    prod = CELL_AW'(y) * CELL_AW'(MAX_WIDTH);
    return prod + CELL_AW'(x);
  endfunction

endpackage

// ===== rtl/core/ufj_ram.sv =====
// ----------------------------------------------------------------------------
// ufj_ram
// Generic RAM with one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ufj_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ufj_ctrl.sv =====
// ----------------------------------------------------------------------------
// ufj_ctrl
// Sequencer around the parent-link memory: clearing pass, two root walks
// and the final link write.
// ----------------------------------------------------------------------------
module ufj_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  ufj_pkg::ufj_req_t  req_i,
  input  logic               take_i,
  output ufj_pkg::ufj_stat_t stat_o
);
  import ufj_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_WALK_O = 3'd2;
  localparam logic [2:0] ST_WALK_E = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state_q, state_d;
  cell_idx_t  clr_q, clr_d;
  cell_idx_t  cur_q, cur_d;
  cell_idx_t  rorg_q, rorg_d;
  cell_idx_t  org_q, org_d;
  cell_idx_t  end_q, end_d;
  logic       carved_q, carved_d;

  logic       we;
  cell_idx_t  waddr;
  ufj_entry_t wdata;
  ufj_entry_t rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  assign rdata = ufj_entry_t'(rdata_raw);

  ufj_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CELL_COUNT)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (cur_d),
    .rdata_o (rdata_raw)
  );

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    cur_d    = cur_q;
    rorg_d   = rorg_q;
    org_d    = org_q;
    end_d    = end_q;
    carved_d = carved_q;
    we       = 1'b0;
    waddr    = clr_q;
    wdata    = '{is_root: 1'b1, up: '0};
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == CELL_AW'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          org_d    = req_i.origin;
          end_d    = req_i.end_cell;
          carved_d = 1'b0;
          cur_d    = req_i.origin;
          state_d  = req_i.bad ? ST_DONE : ST_WALK_O;
        end
      end
      ST_WALK_O: begin
        if (rdata.is_root) begin
          rorg_d  = cur_q;
          cur_d   = end_q;
          state_d = ST_WALK_E;
        end else begin
          cur_d = rdata.up;
        end
      end
      ST_WALK_E: begin
        if (rdata.is_root) begin
          if (cur_q != rorg_q) begin
            we       = 1'b1;
            waddr    = cur_q;
            wdata    = '{is_root: 1'b0, up: org_q};
            carved_d = 1'b1;
          end
          state_d = ST_DONE;
        end else begin
          cur_d = rdata.up;
        end
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      carved_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      carved_q <= carved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    rorg_q <= rorg_d;
    org_q  <= org_d;
    end_q  <= end_d;
  end

  assign stat_o = '{idle:   (state_q == ST_IDLE),
                    done:   (state_q == ST_DONE),
                    carved: carved_q};

endmodule

// ===== rtl/core/grid_union_find_edge_joiner.sv =====
// ----------------------------------------------------------------------------
// grid_union_find_edge_joiner
// Kruskal maze edge joiner over a disjoint-set forest of grid cells.
//
//   Channel   Direction  Handshake               Payload
//   s_axis    in         tvalid/tready           one grid edge
//   m_axis    out        tvalid/tready           one result per edge
//   cfg       in         cfg_we_i                grid width or height
//
// After reset the parent memory is cleared; no edge is taken during that
// pass. An edge inside the grid walks from each of its two cells to its
// root, one read of the parent memory per hop, and links the end root to
// the origin cell if the roots differ. An edge off the grid goes straight to
// the done state. A new edge is taken while the previous result waits in
// the output register; a stalled output holds the sequencer in its done state.
// ----------------------------------------------------------------------------
module grid_union_find_edge_joiner (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cell_x [5:0], cell_y [11:6], edge_dir [12], zero [15:13]
  input  logic [ufj_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // carved [0], origin_x [6:1], origin_y [12:7], end_x [18:13],
  // end_y [24:19], bad_edge [25], zero [31:26]
  output logic [ufj_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [ufj_pkg::DIM_W-1:0]           cfg_data_i
);
  import ufj_pkg::*;

  logic [DIM_W-1:0] width_q, height_q;
  logic [DIM_W-1:0] eff_w, eff_h;

  logic [COORD_W-1:0] in_x, in_y;
  logic               in_dir;
  logic [DIM_W-1:0]   ex_w, ey_w;
  logic               in_bad;
  logic               start;

  logic [COORD_W-1:0] ox_q, oy_q, ex_q, ey_q;
  logic               bad_q;

  ufj_req_t  req;
  ufj_stat_t stat;
  logic      take;

  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_WIDTH:  width_q  <= cfg_data_i;
        REG_GRID_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_w = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
  assign eff_h = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

  assign in_x   = s_axis_tdata[COORD_W-1:0];
  assign in_y   = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_dir = s_axis_tdata[2*COORD_W];

  assign ex_w = DIM_W'(in_x) + ((in_dir == DIR_RIGHT) ? DIM_W'(1) : DIM_W'(0));
  assign ey_w = DIM_W'(in_y) + ((in_dir == DIR_FORWARD) ? DIM_W'(1) : DIM_W'(0));

  assign in_bad = (DIM_W'(in_x) >= eff_w) || (DIM_W'(in_y) >= eff_h) ||
                  (ex_w >= eff_w) || (ey_w >= eff_h);

  assign s_axis_tready = stat.idle;
  assign start         = s_axis_tvalid && s_axis_tready;

  assign req = '{origin:   cell_index(in_x, in_y),
                 end_cell: cell_index(ex_w[COORD_W-1:0], ey_w[COORD_W-1:0]),
                 bad:      in_bad};

  always_ff @(posedge clk_i) begin
    if (start) begin
      ox_q  <= in_x;
      oy_q  <= in_y;
      ex_q  <= ex_w[COORD_W-1:0];
      ey_q  <= ey_w[COORD_W-1:0];
      bad_q <= in_bad;
    end
  end

  ufj_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .take_i  (take),
    .stat_o  (stat)
  );

  assign take = stat.done && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_data_q <= {6'd0, bad_q, ey_q, ex_q, oy_q, ox_q, stat.carved};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grid union-find edge joiner. Edges are sent
// over the input stream, and the bench keeps its own disjoint-set forest of
// the grid to predict whether each edge is carved, rejected or off the grid.
// Every result is checked field by field. The bench visits several grid
// sizes, including zero and sizes above the maximum, inserts random gaps
// on the input stream and applies random backpressure on the output stream.
// ----------------------------------------------------------------------------
module tb_top;
  import ufj_pkg::*;

  localparam int IdleLimit = 40000;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               dir;
  } edge_t;

  typedef struct packed {
    logic               carved;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic               bad;
  } join_result_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data  = '0;
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic                   cfg_we   = 1'b0;
  logic                   cfg_idx  = REG_GRID_WIDTH;
  logic [DIM_W-1:0]       cfg_data = '0;

  edge_t        edges_to_send[$];
  join_result_t pending_results[$];
  edge_t        offered_edge;

  logic          set_is_root[CELL_COUNT];
  cell_idx_t     set_parent[CELL_COUNT];
  logic [DIM_W-1:0] grid_cols = 7'd64;
  logic [DIM_W-1:0] grid_rows = 7'd64;

  int  results_seen = 0;
  int  mismatch_count = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  logic calm_stretch;

  assign calm_stretch = (results_seen >= 400) && (results_seen < 560);

  grid_union_find_edge_joiner u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic cell_idx_t find_set_root(input cell_idx_t node);
    int        hops;
    cell_idx_t walk;
    hops = 0;
    walk = node;
    while (hops < CELL_COUNT && !set_is_root[walk]) begin
      walk = set_parent[walk];
      hops++;
    end
    return walk;
  endfunction

  function automatic join_result_t join_edge(input edge_t e);
    int           w;
    int           h;
    int           ex;
    int           ey;
    cell_idx_t    origin_cell;
    cell_idx_t    end_cell;
    cell_idx_t    origin_root;
    cell_idx_t    end_root;
    join_result_t r;
    w  = (grid_cols > MAX_WIDTH) ? MAX_WIDTH : int'(grid_cols);
    h  = (grid_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(grid_rows);
    ex = int'(e.x);
    ey = int'(e.y);
    if (e.dir == DIR_RIGHT) begin
      ex++;
    end else begin
      ey++;
    end
    r.bad    = (int'(e.x) >= w) || (int'(e.y) >= h) || (ex >= w) || (ey >= h);
    r.carved = 1'b0;
    r.ox     = e.x;
    r.oy     = e.y;
    r.ex     = COORD_W'(ex);
    r.ey     = COORD_W'(ey);
    if (!r.bad) begin
      origin_cell = cell_idx_t'(int'(e.y) * MAX_WIDTH + int'(e.x));
      end_cell    = cell_idx_t'(ey * MAX_WIDTH + ex);
      origin_root = find_set_root(origin_cell);
      end_root    = find_set_root(end_cell);
      if (origin_root != end_root) begin
        set_is_root[end_root] = 1'b0;
        set_parent[end_root]  = origin_cell;
        r.carved              = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic edge_t random_edge(input int w, input int h);
    edge_t e;
    if (w > 0 && h > 0 && $urandom_range(99) < 80) begin
      e.x = COORD_W'($urandom_range(w - 1));
      e.y = COORD_W'($urandom_range(h - 1));
    end else begin
      e.x = COORD_W'($urandom_range(63));
      e.y = COORD_W'($urandom_range(63));
    end
    e.dir = $urandom_range(1) ? DIR_FORWARD : DIR_RIGHT;
    return e;
  endfunction

  // Edge driver: predicts each accepted transaction and offers the next one.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
      s_data  <= '0;
    end else begin
      if (s_valid && s_ready) begin
        pending_results.push_back(join_edge(offered_edge));
      end
      if (!s_valid || s_ready) begin
        if (edges_to_send.size() != 0 && (calm_stretch || $urandom_range(99) >= 29)) begin
          offered_edge = edges_to_send.pop_front();
          s_data  <= {3'b000, offered_edge.dir, offered_edge.y, offered_edge.x};
          s_valid <= 1'b1;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure and one long hold-off.
  always @(posedge clk_i or negedge rst_n) begin
    join_result_t got;
    join_result_t want;
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got.carved = m_data[0];
        got.ox     = m_data[6:1];
        got.oy     = m_data[12:7];
        got.ex     = m_data[18:13];
        got.ey     = m_data[24:19];
        got.bad    = m_data[25];
        if (pending_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Unexpected result transaction: tdata=%h", m_data);
          end
        end else begin
          want = pending_results.pop_front();
          if (got.carved !== want.carved || got.ox !== want.ox || got.oy !== want.oy ||
              got.ex !== want.ex || got.ey !== want.ey || got.bad !== want.bad) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("Mismatch at result %0d: expected carved=%b origin=(%0d,%0d) %s",
                       results_seen, want.carved, want.ox, want.oy, "");
              $display("  expected end=(%0d,%0d) bad=%b",
                       want.ex, want.ey, want.bad);
              $display("  got carved=%b origin=(%0d,%0d) end=(%0d,%0d) bad=%b",
                       got.carved, got.ox, got.oy, got.ex, got.ey, got.bad);
            end
          end
        end
        results_seen++;
        if (results_seen == 120) begin
          stall_left = 300;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= calm_stretch || ($urandom_range(99) >= 29);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    @(posedge clk_i);
    while (edges_to_send.size() != 0 || s_valid || pending_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic set_grid(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows);
    repeat (4) @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_GRID_WIDTH;
    cfg_data <= cols;
    @(posedge clk_i);
    cfg_idx  <= REG_GRID_HEIGHT;
    cfg_data <= rows;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    grid_cols = cols;
    grid_rows = rows;
  endtask

  task automatic push_edge(input int x, input int y, input logic dir);
    edge_t e;
    e.x   = COORD_W'(x);
    e.y   = COORD_W'(y);
    e.dir = dir;
    edges_to_send.push_back(e);
  endtask

  task automatic run_phase(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
                           input int count);
    int w;
    int h;
    w = (cols > MAX_WIDTH) ? MAX_WIDTH : int'(cols);
    h = (rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows);
    set_grid(cols, rows);
    for (int i = 0; i < count / 2; i++) begin
      edges_to_send.push_back(random_edge(w, h));
    end
    wait_drained();
    for (int i = count / 2; i < count; i++) begin
      edges_to_send.push_back(random_edge(w, h));
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < CELL_COUNT; i++) begin
      set_is_root[i] = 1'b1;
      set_parent[i]  = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;

    // Reset grid: joins, a rejection and the far corner of the grid.
    push_edge(0, 0, DIR_RIGHT);
    push_edge(0, 0, DIR_FORWARD);
    push_edge(1, 0, DIR_FORWARD);
    push_edge(0, 1, DIR_RIGHT);
    push_edge(63, 63, DIR_RIGHT);
    push_edge(63, 63, DIR_FORWARD);
    push_edge(63, 0, DIR_RIGHT);
    push_edge(0, 63, DIR_FORWARD);
    push_edge(62, 63, DIR_RIGHT);
    push_edge(63, 62, DIR_FORWARD);
    push_edge(62, 62, DIR_RIGHT);
    push_edge(62, 62, DIR_FORWARD);
    wait_drained();

    set_grid(7'd0, 7'd5);
    push_edge(0, 0, DIR_RIGHT);
    push_edge(0, 0, DIR_FORWARD);
    wait_drained();

    set_grid(7'd1, 7'd1);
    push_edge(0, 0, DIR_RIGHT);
    push_edge(0, 0, DIR_FORWARD);
    wait_drained();

    // Register values above the maximum saturate; earlier links stay in force.
    set_grid(7'd127, 7'd127);
    push_edge(62, 0, DIR_RIGHT);
    push_edge(63, 0, DIR_FORWARD);
    push_edge(63, 62, DIR_RIGHT);
    push_edge(61, 62, DIR_RIGHT);
    push_edge(0, 1, DIR_FORWARD);
    wait_drained();

    run_phase(7'd64, 7'd64, 250);
    run_phase(7'd8, 7'd8, 150);
    run_phase(7'd4, 7'd4, 60);
    run_phase(7'd1, 7'd1, 20);
    run_phase(7'd2, 7'd64, 80);
    run_phase(7'd64, 7'd1, 60);
    run_phase(7'd127, 7'd100, 150);
    run_phase(7'd0, 7'd0, 20);
    run_phase(7'd16, 7'd16, 200);

    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
